### hdl/incremental_pid_with_setpoint_ramp_core_macros.svh
// assertion macros for the incremental pid core
`ifndef INCREMENTAL_PID_WITH_SETPOINT_RAMP_CORE_MACROS_SVH
`define INCREMENTAL_PID_WITH_SETPOINT_RAMP_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define IPID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define IPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ipid_pkg.sv
// shared constants for the incremental pid core
`default_nettype none
package ipid_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_AW         = 5;

    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_ACCEL    = 3'd3;
    localparam logic [2:0] REG_FLOOR    = 3'd4;
    localparam logic [2:0] REG_CEILING  = 3'd5;
    localparam logic [2:0] REG_TARGET   = 3'd6;

    localparam logic REQ_RUN   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;
endpackage
`default_nettype wire

### hdl/incremental_pid_with_setpoint_ramp_core.sv
// incremental pid core: top level with sequencer, shared multiplier and divider
// clear and held steps go straight to the output; a deadband clear ends after the ramp
// throughput: one request at a time, s_tready low while a step is in work or a result waits
// the shared multiplier registers its product; the divider one bit per cycle
// reset: asynchronous active low; state zero, gains zero, limits full range
`default_nettype none
`include "incremental_pid_with_setpoint_ramp_core_macros.svh"
module incremental_pid_with_setpoint_ramp_core
    import ipid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [CFG_AW-1:0]      paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // measured_velocity [31:0], step_time [63:32]
    input  wire [63:0]            s_tdata,
    // req_type
    input  wire                   s_tuser,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // drive_output [31:0]
    output logic [31:0]           m_tdata,
    // in_deadband [0], held_last [1]
    output logic [1:0]            m_tuser
);
    localparam int W = DATA_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam logic signed [W+1:0] VMAX = (W+2)'((64'(1) << (W-1)) - 1);
    localparam logic signed [W+1:0] VMIN = -VMAX - 1;
    localparam logic [W-1:0] DEADBAND = W'(((64'(1) << FRAC_BITS) + 5) / 10);

    typedef enum logic [4:0] {
        S_IDLE, S_MS, S_MW, S_RAMP, S_DB, S_ERR, S_M1, S_M1W, S_M2, S_M2W,
        S_M3, S_M3W, S_M4, S_M4W, S_DIV, S_DIVW, S_SUM, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [W-1:0] gp_reg, gi_reg, gd_reg, floor_reg, ceil_reg, tgt_reg;
    logic [W-2:0]        acc_reg;
    logic signed [W-1:0] sp_reg, e1_reg, e2_reg, drv_reg;
    logic signed [W-1:0] meas_reg, dt_reg, err_reg, dp_reg, di_reg, dd_reg;
    logic signed [W-1:0] ma_reg, mb_reg, mres_reg;
    logic                out_v_reg;
    logic [31:0]         out_d_reg;
    logic [1:0]          out_u_reg;

    function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
        if (v > VMAX) return VMAX[W-1:0];
        if (v < VMIN) return VMIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] s32(input logic [31:0] x);
        logic signed [W+33:0] e;
        e = (W+34)'($signed(x));
        if (e > (W+34)'(VMAX)) return VMAX[W-1:0];
        if (e < (W+34)'(VMIN)) return VMIN[W-1:0];
        return e[W-1:0];
    endfunction

    logic signed [W-1:0] acc_w;
    assign acc_w = s32({1'b0, pwdata[30:0]});

    // shared multiplier: magnitude product, round half away, saturate
    logic [W-1:0]  mag_a, mag_b;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] prod_r;
    logic [2*W-1:0] pq;
    logic           mneg;
    logic signed [W-1:0] mval;
    always_comb
    begin
        mag_a = ma_reg[W-1] ? (~ma_reg + 1'b1) : ma_reg;
        mag_b = mb_reg[W-1] ? (~mb_reg + 1'b1) : mb_reg;
        prod  = mag_a * mag_b;
        mneg  = ma_reg[W-1] != mb_reg[W-1];
    end
    logic [2*W-1:0] prod_reg;
    logic           mneg_reg;
    always_comb
    begin
        prod_r = prod_reg + ((2*W)'(1) << (FRAC_BITS - 1));
        pq     = prod_r >> FRAC_BITS;
        if (mneg_reg)
            mval = (pq > (2*W)'(VMAX) + 1'b1) ? VMIN[W-1:0] : (~pq[W-1:0] + 1'b1);
        else
            mval = (pq > (2*W)'(VMAX)) ? VMAX[W-1:0] : pq[W-1:0];
    end

    logic div_start, div_done;
    logic signed [W-1:0] div_q;
    ipid_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numer(mres_reg),
        .denom(dt_reg), .done(div_done), .quot(div_q)
    );
    assign div_start = (state_reg == S_DIV);

    logic in_xfer, out_xfer, cfg_wr;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;

    // ramp and loop arithmetic
    logic signed [W+1:0] step_w, mstep, nmstep;
    logic signed [W-1:0] step_c, sp_new;
    logic [W-1:0] tgt_mag, sp_mag;
    logic signed [W+1:0] d2w, sumw;
    logic signed [W-1:0] total;
    always_comb
    begin
        step_w = (W+2)'(sat((W+2)'(tgt_reg) - (W+2)'(sp_reg)));
        mstep  = (W+2)'(mres_reg);
        nmstep = -mstep;
        if (step_w > mstep) step_w = mstep;
        if (step_w < nmstep) step_w = nmstep;
        step_c = step_w[W-1:0];
        sp_new = sat((W+2)'(sp_reg) + (W+2)'(step_c));
        tgt_mag = tgt_reg[W-1] ? (~tgt_reg + 1'b1) : tgt_reg;
        sp_mag  = sp_reg[W-1] ? (~sp_reg + 1'b1) : sp_reg;
        d2w  = (W+2)'(err_reg) - ((W+2)'(e1_reg) <<< 1) + (W+2)'(e2_reg);
        sumw = (W+2)'(dp_reg) + (W+2)'(di_reg) + (W+2)'(dd_reg);
        total = sat((W+2)'(drv_reg) + (W+2)'(sat(sumw)));
        if (total < floor_reg) total = floor_reg;
        if (total > ceil_reg) total = ceil_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        mneg_reg <= mneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gp_reg <= '0; gi_reg <= '0; gd_reg <= '0; acc_reg <= '0;
            floor_reg <= VMIN[W-1:0]; ceil_reg <= VMAX[W-1:0]; tgt_reg <= '0;
            sp_reg <= '0; e1_reg <= '0; e2_reg <= '0; drv_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (out_xfer)
                out_v_reg <= 1'b0;
            if (cfg_wr)
            begin
                case (paddr[CFG_AW-1:2])
                    REG_GAIN_P:  gp_reg    <= s32(pwdata);
                    REG_GAIN_I:  gi_reg    <= s32(pwdata);
                    REG_GAIN_D:  gd_reg    <= s32(pwdata);
                    REG_ACCEL:   acc_reg   <= acc_w[W-2:0];
                    REG_FLOOR:   floor_reg <= s32(pwdata);
                    REG_CEILING: ceil_reg  <= s32(pwdata);
                    REG_TARGET:  tgt_reg   <= s32(pwdata);
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        meas_reg <= s32(s_tdata[31:0]);
                        dt_reg   <= s32(s_tdata[63:32]);
                        if (s_tuser == REQ_CLEAR)
                        begin
                            sp_reg <= '0; e1_reg <= '0; e2_reg <= '0; drv_reg <= '0;
                            out_d_reg <= '0; out_u_reg <= 2'b00;
                            state_reg <= S_OUT;
                        end
                        else if (s32(s_tdata[63:32]) <= 0)
                        begin
                            out_d_reg <= 32'(drv_reg); out_u_reg <= 2'b10;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ma_reg <= {1'b0, acc_reg};
                            mb_reg <= s32(s_tdata[63:32]);
                            state_reg <= S_MS;
                        end
                    end
                end
                S_MS:   state_reg <= S_MW;
                S_MW:   begin mres_reg <= mval; state_reg <= S_RAMP; end
                S_RAMP: begin sp_reg <= sp_new; state_reg <= S_DB; end
                S_DB:
                begin
                    if (tgt_mag < DEADBAND && sp_mag < DEADBAND)
                    begin
                        sp_reg <= '0; e1_reg <= '0; e2_reg <= '0; drv_reg <= '0;
                        out_d_reg <= '0; out_u_reg <= 2'b01;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        err_reg <= sat((W+2)'(sp_reg) - (W+2)'(meas_reg));
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    ma_reg <= gp_reg;
                    mb_reg <= sat((W+2)'(err_reg) - (W+2)'(e1_reg));
                    state_reg <= S_M1;
                end
                S_M1:  state_reg <= S_M1W;
                S_M1W:
                begin
                    dp_reg <= mval;
                    ma_reg <= gi_reg; mb_reg <= err_reg;
                    state_reg <= S_M2;
                end
                S_M2:  state_reg <= S_M2W;
                S_M2W: begin ma_reg <= mval; mb_reg <= dt_reg; state_reg <= S_M3; end
                S_M3:  state_reg <= S_M3W;
                S_M3W:
                begin
                    di_reg <= mval;
                    ma_reg <= gd_reg; mb_reg <= sat(d2w);
                    state_reg <= S_M4;
                end
                S_M4:  state_reg <= S_M4W;
                S_M4W: begin mres_reg <= mval; state_reg <= S_DIV; end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        dd_reg <= div_q;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    e2_reg <= e1_reg; e1_reg <= err_reg; drv_reg <= total;
                    out_d_reg <= 32'(total); out_u_reg <= 2'b00;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[CFG_AW-1:2])
            REG_GAIN_P:  prdata = 32'(gp_reg);
            REG_GAIN_I:  prdata = 32'(gi_reg);
            REG_GAIN_D:  prdata = 32'(gd_reg);
            REG_ACCEL:   prdata = 32'(acc_reg);
            REG_FLOOR:   prdata = 32'(floor_reg);
            REG_CEILING: prdata = 32'(ceil_reg);
            REG_TARGET:  prdata = 32'(tgt_reg);
            default:     prdata = '0;
        endcase
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;

    `IPID_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_tready, "input taken while busy")
    `IPID_ASSERT_IMP(a_flags_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]), "both flags set")
    `IPID_ASSERT_NEXT(a_out_follows, clk, rst_n, state_reg == S_OUT, m_tvalid, "result not shown")
    `IPID_ASSERT_IMP(a_held_value, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == 32'd0, "deadband output not zero")
endmodule
`default_nettype wire

### hdl/ipid_div.sv
// restoring divider for the derivative term, one quotient bit per cycle
`default_nettype none
module ipid_div
    import ipid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire signed [DATA_WIDTH-1:0] numer,
    input  wire signed [DATA_WIDTH-1:0] denom,
    output logic                        done,
    output logic signed [DATA_WIDTH-1:0] quot
);
    localparam int NB = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [DATA_WIDTH:0] VMAXU = {2'b00, {(DATA_WIDTH-1){1'b1}}};

    logic [NB-1:0]       dividend_reg;
    logic [DATA_WIDTH:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH:0] q_reg;
    logic                qovf_reg;
    logic                neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                fin_reg;

    logic [DATA_WIDTH+1:0] rem_sh;
    logic                  ge;
    logic [DATA_WIDTH+1:0] rem_sub;
    logic [DATA_WIDTH-1:0] nmag;
    logic [DATA_WIDTH+1:0] rem2;
    logic                  rnd;
    logic [DATA_WIDTH+1:0] qr;
    logic [DATA_WIDTH-1:0] qsat;

    always_comb
    begin
        nmag    = numer[DATA_WIDTH-1] ? (~numer + 1'b1) : numer;
        rem_sh  = {rem_reg, dividend_reg[NB-1]};
        ge      = rem_sh >= {2'b00, den_reg};
        rem_sub = ge ? rem_sh - {2'b00, den_reg} : rem_sh;
        rem2    = {rem_reg, 1'b0};
        rnd     = !qovf_reg && (rem2 >= {2'b00, den_reg});
        qr      = {1'b0, q_reg} + {{(DATA_WIDTH+1){1'b0}}, rnd};
        if (qovf_reg)
            qsat = neg_reg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : VMAXU[DATA_WIDTH-1:0];
        else if (neg_reg)
            qsat = (qr > {1'b0, VMAXU} + 1'b1) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                            : (~qr[DATA_WIDTH-1:0] + 1'b1);
        else
            qsat = (qr > {1'b0, VMAXU}) ? VMAXU[DATA_WIDTH-1:0] : qr[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= CW'(NB);
                dividend_reg <= {nmag, {FRAC_BITS{1'b0}}};
                den_reg      <= denom;
                rem_reg      <= '0;
                q_reg        <= '0;
                qovf_reg     <= 1'b0;
                neg_reg      <= numer[DATA_WIDTH-1];
            end
            else if (busy_reg)
            begin
                rem_reg      <= rem_sub[DATA_WIDTH:0];
                dividend_reg <= {dividend_reg[NB-2:0], 1'b0};
                if (!qovf_reg)
                begin
                    if (q_reg[DATA_WIDTH])
                        qovf_reg <= 1'b1;
                    else
                        q_reg <= {q_reg[DATA_WIDTH-1:0], ge};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign done = fin_reg;
    assign quot = qsat;
endmodule
`default_nettype wire
